[sv/msd_pkg.sv]
// Package for the pointer shake detector: direction codes, configuration
// register indexes, reset values and the configuration bundle type.
// No dependencies.
package msd_pkg;

  // Direction of the last directed move
  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_POS  = 2'd1,
    DIR_NEG  = 2'd2
  } dir_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_SHAKE_ENABLE       = 2'd0,
    CFG_REVERSAL_THRESHOLD = 2'd1,
    CFG_WINDOW_MS          = 2'd2,
    CFG_MIN_STEP           = 2'd3
  } cfg_idx_e;

  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = 16;
  localparam int unsigned ThrWidth     = 4;
  localparam int unsigned WindowWidth  = 16;
  localparam int unsigned StepWidth    = 8;

  // Threshold clamp limits
  localparam logic [ThrWidth-1:0] ThrMin = 4'd3;
  localparam logic [ThrWidth-1:0] ThrMax = 4'd10;

  // Reset values of the configuration registers
  localparam logic                   RstShakeEnable = 1'b1;
  localparam logic [ThrWidth-1:0]    RstThreshold   = 4'd5;
  localparam logic [WindowWidth-1:0] RstWindowMs    = 16'd1000;
  localparam logic [StepWidth-1:0]   RstMinStep     = 8'd6;

  // Configuration bundle handed to the update logic
  typedef struct packed {
    logic                   shake_enable;
    logic [ThrWidth-1:0]    reversal_threshold;
    logic [WindowWidth-1:0] window_ms;
    logic [StepWidth-1:0]   min_step;
  } cfg_t;

endpackage

[sv/msd_step.sv]
// Combinational update of the shake detector state for one pointer request.
// Depends on msd_pkg (cfg_t, dir_e, threshold limits).
module msd_step #(
  parameter int unsigned COORD_WIDTH = 16,
  parameter int unsigned TIME_WIDTH  = 32
) (
  input  msd_pkg::cfg_t                  cfg_i,
  input  logic                           armed_i,
  input  logic signed [COORD_WIDTH-1:0]  pos_x_i,
  input  logic signed [COORD_WIDTH-1:0]  pos_y_i,
  input  logic        [TIME_WIDTH-1:0]   time_ms_i,
  input  logic signed [COORD_WIDTH-1:0]  last_x_i,
  input  logic signed [COORD_WIDTH-1:0]  last_y_i,
  input  logic        [TIME_WIDTH-1:0]   window_start_i,
  input  logic [msd_pkg::ThrWidth-1:0]   reversals_i,
  input  msd_pkg::dir_e                  last_dir_i,
  output logic                           update_o,
  output logic        [TIME_WIDTH-1:0]   window_start_o,
  output logic [msd_pkg::ThrWidth-1:0]   reversals_o,
  output msd_pkg::dir_e                  last_dir_o,
  output logic                           shake_o
);

  localparam int unsigned DW = COORD_WIDTH + 1;

  logic signed [DW-1:0]               dx;
  logic signed [DW-1:0]               dy;
  logic        [DW-1:0]               mag_x;
  logic        [DW-1:0]               mag_y;
  logic signed [DW-1:0]               delta;
  logic        [DW-1:0]               mag_d;
  logic                               moved;
  msd_pkg::dir_e                      dir;
  logic        [TIME_WIDTH-1:0]       elapsed;
  logic                               expired;
  logic [msd_pkg::ThrWidth-1:0]       thr;
  logic [msd_pkg::ThrWidth-1:0]       rev_inc;
  logic                               at_origin;

  always_comb begin
    // Dominant-axis delta, x wins ties
    dx    = {pos_x_i[COORD_WIDTH-1], pos_x_i} - {last_x_i[COORD_WIDTH-1], last_x_i};
    dy    = {pos_y_i[COORD_WIDTH-1], pos_y_i} - {last_y_i[COORD_WIDTH-1], last_y_i};
    mag_x = dx[DW-1] ? DW'(-dx) : DW'(dx);
    mag_y = dy[DW-1] ? DW'(-dy) : DW'(dy);
    if (mag_x >= mag_y) begin
      delta = dx;
      mag_d = mag_x;
    end else begin
      delta = dy;
      mag_d = mag_y;
    end
    moved = mag_d >= DW'(cfg_i.min_step);
    dir   = (!delta[DW-1] && (delta != '0)) ? msd_pkg::DIR_POS : msd_pkg::DIR_NEG;

    // Wrapping elapsed time against the window
    elapsed = time_ms_i - window_start_i;
    expired = elapsed > TIME_WIDTH'(cfg_i.window_ms);

    // Clamped threshold
    if (cfg_i.reversal_threshold < msd_pkg::ThrMin) begin
      thr = msd_pkg::ThrMin;
    end else if (cfg_i.reversal_threshold > msd_pkg::ThrMax) begin
      thr = msd_pkg::ThrMax;
    end else begin
      thr = cfg_i.reversal_threshold;
    end
    rev_inc = reversals_i + msd_pkg::ThrWidth'(1);

    at_origin = (last_x_i == '0) && (last_y_i == '0);

    // Defaults: hold state
    update_o       = cfg_i.shake_enable && armed_i;
    window_start_o = window_start_i;
    reversals_o    = reversals_i;
    last_dir_o     = last_dir_i;
    shake_o        = 1'b0;

    if (update_o) begin
      if (at_origin) begin
        window_start_o = time_ms_i;
      end else if (moved) begin
        last_dir_o = dir;
        if (expired) begin
          reversals_o    = '0;
          window_start_o = time_ms_i;
        end else if ((last_dir_i != msd_pkg::DIR_NONE) && (dir != last_dir_i)) begin
          if (rev_inc >= thr) begin
            reversals_o    = '0;
            window_start_o = '0;
            shake_o        = 1'b1;
          end else begin
            reversals_o = rev_inc;
          end
        end
      end
    end
  end

endmodule

[sv/mouse_shake_detector_unit.sv]
// Pointer shake detector: counts direction reversals of a timestamped
// pointer stream inside a time window and flags a shake.
// Pipeline: the input register, then the update logic into the result register.
// Throughput: one request per cycle while the output is not stalled; the state
// update loop is combinational from the tracking state back into it.
// Reset: configuration returns to its defaults, tracking state clears.
module mouse_shake_detector_unit #(
  parameter int unsigned COORD_WIDTH = 16,
  parameter int unsigned TIME_WIDTH  = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [msd_pkg::CfgIdxWidth-1:0]      cfg_idx_i,
  input  logic [msd_pkg::CfgDataWidth-1:0]     cfg_data_i,
  // input channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [COORD_WIDTH-1:0]        pos_x_i,
  input  logic signed [COORD_WIDTH-1:0]        pos_y_i,
  input  logic        [TIME_WIDTH-1:0]         time_ms_i,
  input  logic                                 armed_i,
  // output channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 shake_detected_o,
  output logic [msd_pkg::ThrWidth-1:0]         reversal_count_o
);

  // Configuration registers
  msd_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.shake_enable       <= msd_pkg::RstShakeEnable;
      cfg_q.reversal_threshold <= msd_pkg::RstThreshold;
      cfg_q.window_ms          <= msd_pkg::RstWindowMs;
      cfg_q.min_step           <= msd_pkg::RstMinStep;
    end else if (cfg_we_i) begin
      unique case (msd_pkg::cfg_idx_e'(cfg_idx_i))
        msd_pkg::CFG_SHAKE_ENABLE:
          cfg_q.shake_enable <= cfg_data_i[0];
        msd_pkg::CFG_REVERSAL_THRESHOLD:
          cfg_q.reversal_threshold <= cfg_data_i[msd_pkg::ThrWidth-1:0];
        msd_pkg::CFG_WINDOW_MS:
          cfg_q.window_ms <= cfg_data_i[msd_pkg::WindowWidth-1:0];
        msd_pkg::CFG_MIN_STEP:
          cfg_q.min_step <= cfg_data_i[msd_pkg::StepWidth-1:0];
        default: ;
      endcase
    end
  end

  // Handshake control
  logic in_valid_q;
  logic out_valid_q;
  logic out_ready;
  logic advance;
  logic in_accept;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Input register
  logic signed [COORD_WIDTH-1:0] pos_x_q;
  logic signed [COORD_WIDTH-1:0] pos_y_q;
  logic        [TIME_WIDTH-1:0]  time_ms_q;
  logic                          armed_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pos_x_q   <= pos_x_i;
      pos_y_q   <= pos_y_i;
      time_ms_q <= time_ms_i;
      armed_q   <= armed_i;
    end
  end

  // Tracking state
  logic signed [COORD_WIDTH-1:0]    last_x_q;
  logic signed [COORD_WIDTH-1:0]    last_y_q;
  logic        [TIME_WIDTH-1:0]     window_start_q;
  logic        [TIME_WIDTH-1:0]     window_start_d;
  logic [msd_pkg::ThrWidth-1:0]     reversals_q;
  logic [msd_pkg::ThrWidth-1:0]     reversals_d;
  msd_pkg::dir_e                    last_dir_q;
  msd_pkg::dir_e                    last_dir_d;
  logic                             update;
  logic                             shake_d;

  msd_step #(
    .COORD_WIDTH (COORD_WIDTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_step (
    .cfg_i          (cfg_q),
    .armed_i        (armed_q),
    .pos_x_i        (pos_x_q),
    .pos_y_i        (pos_y_q),
    .time_ms_i      (time_ms_q),
    .last_x_i       (last_x_q),
    .last_y_i       (last_y_q),
    .window_start_i (window_start_q),
    .reversals_i    (reversals_q),
    .last_dir_i     (last_dir_q),
    .update_o       (update),
    .window_start_o (window_start_d),
    .reversals_o    (reversals_d),
    .last_dir_o     (last_dir_d),
    .shake_o        (shake_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_x_q       <= '0;
      last_y_q       <= '0;
      window_start_q <= '0;
      reversals_q    <= '0;
      last_dir_q     <= msd_pkg::DIR_NONE;
    end else if (advance) begin
      if (update) begin
        last_x_q <= pos_x_q;
        last_y_q <= pos_y_q;
      end
      window_start_q <= window_start_d;
      reversals_q    <= reversals_d;
      last_dir_q     <= last_dir_d;
    end
  end

  // Result register
  logic                         shake_q;
  logic [msd_pkg::ThrWidth-1:0] count_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      shake_q <= shake_d;
      count_q <= reversals_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign shake_detected_o = shake_q;
  assign reversal_count_o = count_q;

endmodule

[tb/sv/mouse_shake_detector_unit_tb.sv]
// Self-checking testbench for mouse_shake_detector_unit: a directed table
// followed by random shake sequences, each result checked against a local tracker
// or a fixed expectation. Depends on msd_pkg and the RTL of mouse_shake_detector_unit.
`timescale 1ns / 1ps

module mouse_shake_detector_unit_tb;

  localparam int SettleCycles = 4;   // pipeline drain plus margin

  typedef struct {
    logic       shake;
    logic [3:0] count;
  } res_t;

  typedef enum {ROW_SAMPLE, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e          kind;
    msd_pkg::cfg_idx_e  idx;
    logic [15:0]        data;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [31:0]        t;
    logic               armed;
    logic               fixed;
    logic               shake;
    logic [3:0]         cnt;
  } row_t;

  // DUT connections
  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  msd_pkg::cfg_idx_e  cfg_idx;
  logic [15:0]        cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic [31:0]        time_ms;
  logic               armed;
  logic               out_valid;
  logic               out_stall;
  logic               shake_detected;
  logic [3:0]         reversal_count;

  // typed expectation carried alongside a directed request
  logic               fix_en;
  logic               fix_shake;
  logic [3:0]         fix_cnt;

  // shake tracker state and its copy of the configuration
  logic signed [15:0] trk_last_x;
  logic signed [15:0] trk_last_y;
  logic [31:0]        trk_win_start;
  logic [3:0]         trk_revs;
  msd_pkg::dir_e      trk_dir;
  msd_pkg::cfg_t      trk_cfg;

  res_t pending_res[$];
  row_t plan[$];
  int   mismatches = 0;
  int   burst_left = 0;

  // random generator state
  logic signed [15:0] gx, gy;
  logic [31:0]        gt;
  bit                 g_neg, g_on_y;
  int                 ph_win, ph_step;

  mouse_shake_detector_unit u_top (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .pos_x_i          (pos_x),
    .pos_y_i          (pos_y),
    .time_ms_i        (time_ms),
    .armed_i          (armed),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .shake_detected_o (shake_detected),
    .reversal_count_o (reversal_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shake tracker: one sample in, expected result out
  function automatic res_t track_sample(logic signed [15:0] x, logic signed [15:0] y,
                                        logic [31:0] t, logic a);
    int            dx, dy, delta, amag;
    logic [31:0]   elapsed;
    logic [3:0]    thr;
    msd_pkg::dir_e d;
    res_t          r;
    r.shake = 1'b0;
    if (trk_cfg.shake_enable && a) begin
      if (trk_last_x == 0 && trk_last_y == 0) begin
        // no previous point: store and open the window
        trk_last_x    = x;
        trk_last_y    = y;
        trk_win_start = t;
      end else begin
        dx = int'(x) - int'(trk_last_x);
        dy = int'(y) - int'(trk_last_y);
        // dominant axis, x wins a tie
        delta = ((dx < 0 ? -dx : dx) >= (dy < 0 ? -dy : dy)) ? dx : dy;
        amag  = delta < 0 ? -delta : delta;
        trk_last_x = x;
        trk_last_y = y;
        if (amag >= int'(trk_cfg.min_step)) begin
          d       = (delta > 0) ? msd_pkg::DIR_POS : msd_pkg::DIR_NEG;
          elapsed = t - trk_win_start;
          if (elapsed > 32'(trk_cfg.window_ms)) begin
            trk_revs      = '0;
            trk_win_start = t;
            trk_dir       = d;
          end else if (trk_dir != msd_pkg::DIR_NONE && d != trk_dir) begin
            thr = trk_cfg.reversal_threshold;
            if (thr < msd_pkg::ThrMin) thr = msd_pkg::ThrMin;
            if (thr > msd_pkg::ThrMax) thr = msd_pkg::ThrMax;
            trk_revs = trk_revs + 4'd1;
            trk_dir  = d;
            if (trk_revs >= thr) begin
              trk_revs      = '0;
              trk_win_start = '0;
              r.shake       = 1'b1;
            end
          end else begin
            trk_dir = d;
          end
        end
      end
    end
    r.count = trk_revs;
    return r;
  endfunction

  function automatic row_t sample_row(int x, int y, logic [31:0] t, bit a);
    row_t r;
    r.kind  = ROW_SAMPLE;
    r.idx   = msd_pkg::CFG_SHAKE_ENABLE;
    r.data  = '0;
    r.x     = 16'(x);
    r.y     = 16'(y);
    r.t     = t;
    r.armed = a;
    r.fixed = 1'b0;
    r.shake = 1'b0;
    r.cnt   = '0;
    return r;
  endfunction

  function automatic row_t checked_row(int x, int y, logic [31:0] t, bit a,
                                       bit shake, int cnt);
    row_t r;
    r       = sample_row(x, y, t, a);
    r.fixed = 1'b1;
    r.shake = shake;
    r.cnt   = 4'(cnt);
    return r;
  endfunction

  function automatic row_t reg_row(msd_pkg::cfg_idx_e idx, int data);
    row_t r;
    r      = sample_row(0, 0, '0, 1'b0);
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.data = 16'(data);
    return r;
  endfunction

  // Result check, request tracking and config shadowing on one edge
  always @(posedge clk) begin : scoreboard
    res_t want, pred;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_res.size() == 0) begin
          $display("%0t: unexpected result shake=%0b count=%0d", $time,
                   shake_detected, reversal_count);
          mismatches++;
        end else begin
          want = pending_res.pop_front();
          if (shake_detected !== want.shake) begin
            $display("%0t: shake_detected expected %0b actual %0b", $time,
                     want.shake, shake_detected);
            mismatches++;
          end
          if (reversal_count !== want.count) begin
            $display("%0t: reversal_count expected %0d actual %0d", $time,
                     want.count, reversal_count);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        pred = track_sample(pos_x, pos_y, time_ms, armed);
        if (fix_en) begin
          pred.shake = fix_shake;
          pred.count = fix_cnt;
        end
        pending_res.insert(pending_res.size(), pred);
      end
      if (cfg_we) begin
        case (cfg_idx)
          msd_pkg::CFG_SHAKE_ENABLE:
            trk_cfg.shake_enable = cfg_data[0];
          msd_pkg::CFG_REVERSAL_THRESHOLD:
            trk_cfg.reversal_threshold = cfg_data[msd_pkg::ThrWidth-1:0];
          msd_pkg::CFG_WINDOW_MS:
            trk_cfg.window_ms = cfg_data[msd_pkg::WindowWidth-1:0];
          msd_pkg::CFG_MIN_STEP:
            trk_cfg.min_step = cfg_data[msd_pkg::StepWidth-1:0];
          default: ;
        endcase
      end
    end
  end

  // Receiver: stall segments of random style, plus two long hold-offs
  int rx_seen = 0, hold_left = 0, seg_left = 0, seg_mode = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) rx_seen++;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (out_valid && !out_stall && (rx_seen == 300 || rx_seen == 900)) begin
        hold_left = 80;
        out_stall <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(10, 80);
          seg_mode = $urandom_range(0, 3);
        end
        seg_left--;
        case (seg_mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= 1'($urandom_range(0, 1));
          2:       out_stall <= (seg_left % 4 == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Offer one request; valid stays up within a burst
  task automatic offer(logic signed [15:0] x, logic signed [15:0] y, logic [31:0] t,
                       logic a, logic fix, logic fs, logic [3:0] fc);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid  <= 1'b1;
    pos_x     <= x;
    pos_y     <= y;
    time_ms   <= t;
    armed     <= a;
    fix_en    <= fix;
    fix_shake <= fs;
    fix_cnt   <= fc;
    do @(posedge clk); while (in_stall);
    burst_left--;
  endtask

  // Wait until every result is back and the pipeline is empty
  task automatic settle();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(msd_pkg::cfg_idx_e idx, logic [15:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Next random sample: mostly back-and-forth moves, some noise
  task automatic gen_sample(output logic signed [15:0] x, output logic signed [15:0] y,
                            output logic [31:0] t, output logic a);
    int roll, step, jit;
    roll = $urandom_range(0, 99);
    a    = 1'b1;
    if (roll < 80) begin
      if ($urandom_range(0, 4) != 0) g_neg = !g_neg;
      if ($urandom_range(0, 9) == 0) g_on_y = !g_on_y;
      step = ($urandom_range(0, 9) == 0) ? $urandom_range(0, ph_step)
                                         : ph_step + $urandom_range(0, 24);
      if (g_neg) step = -step;
      jit = int'($urandom_range(0, 2)) - 1;
      if (g_on_y) begin
        gy = gy + 16'(step);
        gx = gx + 16'(jit);
      end else begin
        gx = gx + 16'(step);
        gy = gy + 16'(jit);
      end
      // a few moves land past the window
      if (roll < 72) gt = gt + $urandom_range(0, ph_win / 6 + 1);
      else           gt = gt + 32'(ph_win) + $urandom_range(1, 3000);
      a = ($urandom_range(0, 29) != 0);
      x = gx; y = gy; t = gt;
    end else if (roll < 86) begin
      gx = '0; gy = '0;
      gt = gt + $urandom_range(0, 4);
      x = gx; y = gy; t = gt;
    end else if (roll < 96) begin
      gx = 16'($urandom);
      gy = 16'($urandom);
      gt = $urandom;
      a  = 1'($urandom_range(0, 1));
      x = gx; y = gy; t = gt;
    end else begin
      // not armed: position ignored, tracker keeps its point
      x = 16'($urandom);
      y = 16'($urandom);
      t = $urandom;
      a = 1'b0;
    end
  endtask

  initial begin : stimulus
    logic signed [15:0] sx, sy;
    logic [31:0]        st;
    logic               sa;
    int                 en, thr, n;

    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = msd_pkg::CFG_SHAKE_ENABLE;
    cfg_data  = '0;
    in_valid  = 1'b0;
    pos_x     = '0;
    pos_y     = '0;
    time_ms   = '0;
    armed     = 1'b0;
    out_stall = 1'b0;
    fix_en    = 1'b0;
    fix_shake = 1'b0;
    fix_cnt   = '0;

    trk_last_x    = '0;
    trk_last_y    = '0;
    trk_win_start = '0;
    trk_revs      = '0;
    trk_dir       = msd_pkg::DIR_NONE;
    trk_cfg.shake_enable       = msd_pkg::RstShakeEnable;
    trk_cfg.reversal_threshold = msd_pkg::RstThreshold;
    trk_cfg.window_ms          = msd_pkg::RstWindowMs;
    trk_cfg.min_step           = msd_pkg::RstMinStep;
    gx = 16'sd40; gy = 16'sd40; gt = '0; g_neg = 1'b0; g_on_y = 1'b0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset configuration
    plan = '{
      checked_row(0, 0, 0, 1, 0, 0),               // origin: store only
      checked_row(100, 0, 10, 1, 0, 0),            // last is origin: store only
      sample_row(110, 0, 20, 1),
      sample_row(100, 0, 30, 1),
      sample_row(110, 0, 40, 1),
      sample_row(100, 0, 50, 1),
      sample_row(110, 0, 60, 1),
      checked_row(100, 0, 70, 1, 1, 0),            // fifth reversal: shake
      checked_row(500, 500, 80, 0, 0, 0),          // not armed
      sample_row(103, 0, 90, 1),                   // below min step
      sample_row(110, 0, 1500, 1),                 // window expired
      sample_row(100, 0, 1510, 1),
      sample_row(110, -10, 1520, 1),               // tie goes to x
      sample_row(110, 20, 1530, 1),                // y dominant
      checked_row(-32768, 32767, 1540, 1, 0, 3),
      checked_row(32767, -32768, 1550, 1, 0, 4),
      checked_row(-32768, -32768, 32'hFFFF_FFFF, 1, 0, 0),
      sample_row(-32758, -32768, 5, 1),            // elapsed wraps
      sample_row(0, 0, 10, 1),                     // real sample at origin
      sample_row(50, 50, 20, 1),                   // stored as first point
      sample_row(40, 50, 1020, 1),                 // elapsed equals window
      sample_row(50, 50, 1021, 1),                 // one past the window
      reg_row(msd_pkg::CFG_MIN_STEP, 0),
      reg_row(msd_pkg::CFG_REVERSAL_THRESHOLD, 0), // clamps up to 3
      sample_row(50, 50, 1030, 1),                 // zero delta counts negative
      sample_row(51, 50, 1050, 1),
      checked_row(50, 50, 1060, 1, 1, 0),
      reg_row(msd_pkg::CFG_SHAKE_ENABLE, 0),
      checked_row(70, 50, 1070, 1, 0, 0),          // disabled
      reg_row(msd_pkg::CFG_SHAKE_ENABLE, 1)
    };
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        settle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        offer(plan[i].x, plan[i].y, plan[i].t, plan[i].armed,
              plan[i].fixed, plan[i].shake, plan[i].cnt);
      end
    end

    // Random part, one configuration per phase
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin en = 1; thr = 5;  ph_win = 1000;  ph_step = 6;   end
        1: begin en = 1; thr = 0;  ph_win = 1;     ph_step = 1;   end
        2: begin en = 1; thr = 15; ph_win = 65535; ph_step = 255; end
        3: begin en = 1; thr = 10; ph_win = $urandom_range(200, 5000); ph_step = 0; end
        4: begin en = 0; thr = 4;  ph_win = 1000;  ph_step = 6;   end
        5: begin
          en      = 1;
          thr     = $urandom_range(0, 15);
          ph_win  = $urandom_range(1, 65535);
          ph_step = $urandom_range(0, 255);
        end
        default: begin en = 1; thr = 5; ph_win = 1000; ph_step = 6; end
      endcase
      settle();
      write_reg(msd_pkg::CFG_SHAKE_ENABLE, 16'(en));
      write_reg(msd_pkg::CFG_REVERSAL_THRESHOLD, 16'(thr));
      write_reg(msd_pkg::CFG_WINDOW_MS, 16'(ph_win));
      write_reg(msd_pkg::CFG_MIN_STEP, 16'(ph_step));
      n = (ph == 4) ? 100 : 210;
      repeat (n) begin
        gen_sample(sx, sy, st, sa);
        offer(sx, sy, st, sa, 1'b0, 1'b0, '0);
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

[files.f]
sv/msd_pkg.sv
sv/msd_step.sv
sv/mouse_shake_detector_unit.sv
tb/sv/mouse_shake_detector_unit_tb.sv
